// ===== rtl/core/mhdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhdc_pkg;

    // Fixed-point word and register widths
    localparam int WORD_W   = 64;
    localparam int GAMMA_W  = 34;
    localparam int FLOOR_W  = 63;
    localparam int CFG_IDX_W = 2;

    // Restoring divider: one quotient bit per step over a 128-bit dividend
    localparam int DIV_N_W    = 128;
    localparam int DIV_STEPS  = 128;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [WORD_W-1:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] SMIN_MAG = 64'h8000_0000_0000_0000;

    // Register reset values
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 34'd2863311531;
    localparam logic [FLOOR_W-1:0] DFLOOR_RESET = 63'd1;
    localparam logic [FLOOR_W-1:0] PFLOOR_RESET = 63'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAMMA_MINUS_ONE = 2'd0,
        CFG_DENSITY_FLOOR   = 2'd1,
        CFG_PRESSURE_FLOOR  = 2'd2
    } cfg_index_t;

    // Partial remainder and the dividend/quotient shift word
    typedef struct packed {
        logic [WORD_W-1:0]  rem;
        logic [DIV_N_W-1:0] nq;
    } div_state_t;

    // Shift in one dividend bit, subtract the divisor when it fits
    function automatic div_state_t div_step(input div_state_t s, input logic [WORD_W-1:0] d);
        logic [WORD_W:0] r2;
        logic            take;
        div_state_t      o;
        r2     = {s.rem, s.nq[DIV_N_W-1]};
        take   = (r2 >= {1'b0, d});
        o.rem  = take ? (r2[WORD_W-1:0] - d) : r2[WORD_W-1:0];
        o.nq   = {s.nq[DIV_N_W-2:0], take};
        return o;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mhdc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Conserved state of one zone
interface mhdc_zone_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] density_in;
    logic signed [63:0] momentum_x;
    logic signed [63:0] momentum_y;
    logic signed [63:0] momentum_z;
    logic signed [63:0] field_x_in;
    logic signed [63:0] field_y_in;
    logic signed [63:0] field_z_in;
    logic signed [63:0] energy_in;
    logic               last_zone;

    modport source (
        output valid, density_in, momentum_x, momentum_y, momentum_z,
               field_x_in, field_y_in, field_z_in, energy_in, last_zone,
        input  ready
    );
    modport sink (
        input  valid, density_in, momentum_x, momentum_y, momentum_z,
               field_x_in, field_y_in, field_z_in, energy_in, last_zone,
        output ready
    );
endinterface

// Primitive state of one zone plus failure flags
interface mhdc_prim_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] density_out;
    logic signed [63:0] velocity_x;
    logic signed [63:0] velocity_y;
    logic signed [63:0] velocity_z;
    logic signed [63:0] field_x_out;
    logic signed [63:0] field_y_out;
    logic signed [63:0] field_z_out;
    logic signed [63:0] pressure_out;
    logic signed [63:0] energy_out;
    logic               zone_failed;
    logic               negative_density;
    logic               run_failed;

    modport source (
        output valid, density_out, velocity_x, velocity_y, velocity_z,
               field_x_out, field_y_out, field_z_out, pressure_out, energy_out,
               zone_failed, negative_density, run_failed,
        input  ready
    );
    modport sink (
        input  valid, density_out, velocity_x, velocity_y, velocity_z,
               field_x_out, field_y_out, field_z_out, pressure_out, energy_out,
               zone_failed, negative_density, run_failed,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/mhdc_div_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fully pipelined 128-by-64 unsigned restoring divider, one quotient bit per stage
module mhdc_div_pipe (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [mhdc_pkg::DIV_N_W-1:0] num,
    input  wire logic [mhdc_pkg::WORD_W-1:0]  den,
    output logic      [mhdc_pkg::DIV_N_W-1:0] quo
);

    mhdc_pkg::div_state_t             st_reg  [mhdc_pkg::DIV_STEPS];
    logic [mhdc_pkg::WORD_W-1:0]      den_reg [mhdc_pkg::DIV_STEPS-1];
    mhdc_pkg::div_state_t             init;

    assign init.rem = '0;
    assign init.nq  = num;

    // Advance every stage together; the divisor travels with its dividend
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]  <= mhdc_pkg::div_step(init, den);
            den_reg[0] <= den;
            for (int i = 1; i < mhdc_pkg::DIV_STEPS; i++)
            begin
                st_reg[i] <= mhdc_pkg::div_step(st_reg[i-1], den_reg[i-1]);
                if (i < mhdc_pkg::DIV_STEPS - 1)
                begin
                    den_reg[i] <= den_reg[i-1];
                end
            end
        end
    end

    assign quo = st_reg[mhdc_pkg::DIV_STEPS-1].nq;

endmodule

`default_nettype wire

// ===== rtl/core/mhd_conservative_to_primitive.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ideal-gas MHD conserved-to-primitive conversion, one zone per word.
// zone: valid/ready channel carrying density, momenta, field, energy and
//   the last_zone mark; a word moves when valid and ready are both high.
// prim: valid/ready channel carrying density, velocities, field, pressure,
//   energy and the three failure flags.
// cfg_we/cfg_index/cfg_data: register writes (gamma minus one, density
//   floor, pressure floor), taken at any clock edge with cfg_we high; write
//   only while no zone is in flight.
// From zone acceptance to the prim word the path has 4 stages of
//   magnitude and squaring, 128 stages of the pipelined 128/64 dividers
//   (one quotient bit per stage) and 5 stages of energy and pressure.
// Throughput is one zone per cycle unless prim stalls or the floor divider runs.
// The quotient pressure_floor/gamma_minus_one comes from a single serial
//   divider that restarts after reset and after each write of
//   gamma_minus_one or pressure_floor; zone.ready is low while it runs.
// Reset clears all valid bits, restores register defaults and clears the
//   sticky density-failure bit.
// When prim stalls, the whole pipeline holds; zone.ready drops the same cycle.
module mhd_conservative_to_primitive (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mhdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mhdc_pkg::FLOOR_W-1:0]    cfg_data,
    mhdc_zone_if.sink                            zone,
    mhdc_prim_if.source                          prim
);

    localparam int W  = mhdc_pkg::WORD_W;
    localparam int NW = mhdc_pkg::DIV_N_W;
    localparam int NS = mhdc_pkg::DIV_STEPS;

    typedef struct packed {
        logic [W-1:0]      rho;
        logic [2:0][W-1:0] mag;
        logic [2:0]        msgn;
        logic [2:0]        mzero;
        logic [2:0][W-1:0] fmag;
        logic [2:0][W-1:0] field;
        logic [W-1:0]      energy;
        logic              neg;
        logic              run_failed;
    } front_t;

    typedef struct packed {
        logic [W-1:0]      rho;
        logic [2:0]        msgn;
        logic [2:0]        mzero;
        logic [2:0][W-1:0] field;
        logic [W-1:0]      energy;
        logic [95:0]       b2s;
        logic              m2nz;
        logic              neg;
        logic              run_failed;
    } side_t;

    typedef struct packed {
        logic [W-1:0]      rho;
        logic [2:0][W-1:0] field;
        logic [2:0][W-1:0] vel;
        logic [W-1:0]      eng;
        logic [W-1:0]      kinb2;
        logic [W-1:0]      flr;
        logic              neg;
        logic              failed;
        logic              run_failed;
    } post_t;

    // Configuration registers
    logic [mhdc_pkg::GAMMA_W-1:0] gmo_reg;
    logic [mhdc_pkg::FLOOR_W-1:0] dfl_reg;
    logic [mhdc_pkg::FLOOR_W-1:0] pfl_reg;

    // Serial floor divider
    logic                           fd_load_reg;
    logic [mhdc_pkg::DIV_CNT_W-1:0] fd_cnt_reg;
    mhdc_pkg::div_state_t           fd_reg;
    logic                           fd_busy;
    logic                           fq_big;

    logic seen_reg;
    logic en;
    logic acc;

    // Pipeline registers
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    front_t            s1_reg, s2_reg, s3_reg, s4_reg;
    logic [5:0][W-1:0] p00_reg, p01_reg, p11_reg;
    logic [5:0][NW-1:0] sq_reg;
    logic [NW-1:0]     m2_reg, b2_reg;
    front_t            s1_next;

    logic [NS-1:0]     dlv_reg;
    side_t             dl_reg [NS];
    side_t             dl_in;

    logic [2:0][NW-1:0] vq;
    logic [NW-1:0]      kq;

    logic              p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic              p4_valid_reg, p5_valid_reg;
    post_t             p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    post_t             p1_next, p2_next, p5_next;
    logic              p3_ok_reg, p4_ok_reg;
    logic [W-1:0]      p3_diff_reg;
    logic [W-1:0]      p4_pa_reg, p4_pb_reg;
    logic [W+1:0]      p4_pc_reg;
    logic [W-1:0]      p5_pres_reg;
    logic [W-1:0]      p5_pres_next;

    side_t             dt;
    logic [NW-1:0]     kin;
    logic [NW-1:0]     ksum;
    logic [W:0]        fsum;
    logic [W-1:0]      eng1;
    logic [W+2:0]      psum;

    assign en  = !p5_valid_reg || prim.ready;
    assign zone.ready = en && !fd_busy;
    assign acc = zone.valid && zone.ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gmo_reg <= mhdc_pkg::GAMMA_RESET;
            dfl_reg <= mhdc_pkg::DFLOOR_RESET;
            pfl_reg <= mhdc_pkg::PFLOOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mhdc_pkg::CFG_GAMMA_MINUS_ONE: gmo_reg <= cfg_data[mhdc_pkg::GAMMA_W-1:0];
                mhdc_pkg::CFG_DENSITY_FLOOR:   dfl_reg <= cfg_data;
                mhdc_pkg::CFG_PRESSURE_FLOOR:  pfl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Restart the floor division after reset and after a relevant write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fd_load_reg <= 1'b1;
            fd_cnt_reg  <= '0;
        end
        else if (cfg_we && (cfg_index == mhdc_pkg::CFG_GAMMA_MINUS_ONE ||
                            cfg_index == mhdc_pkg::CFG_PRESSURE_FLOOR))
        begin
            fd_load_reg <= 1'b1;
            fd_cnt_reg  <= '0;
        end
        else if (fd_load_reg)
        begin
            fd_load_reg <= 1'b0;
            fd_cnt_reg  <= mhdc_pkg::DIV_CNT_W'(NS);
        end
        else if (fd_cnt_reg != '0)
        begin
            fd_cnt_reg <= fd_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fd_load_reg)
        begin
            fd_reg.rem <= '0;
            fd_reg.nq  <= {33'b0, pfl_reg, 32'b0};
        end
        else if (fd_cnt_reg != '0)
        begin
            fd_reg <= mhdc_pkg::div_step(fd_reg, {30'b0, gmo_reg});
        end
    end

    assign fd_busy = fd_load_reg || (fd_cnt_reg != '0);
    assign fq_big  = (fd_reg.nq[NW-1:W] != '0);

    // Stage 1: density floor, magnitudes, run flag
    always_comb
    begin
        logic [2:0][W-1:0] mom;
        logic [2:0][W-1:0] fld;
        mom = {zone.momentum_z, zone.momentum_y, zone.momentum_x};
        fld = {zone.field_z_in, zone.field_y_in, zone.field_x_in};
        s1_next.neg        = zone.density_in[W-1];
        s1_next.rho        = zone.density_in[W-1] ? {1'b0, dfl_reg} : zone.density_in;
        s1_next.field      = fld;
        s1_next.energy     = zone.energy_in;
        s1_next.run_failed = zone.last_zone && (seen_reg || zone.density_in[W-1]);
        for (int k = 0; k < 3; k++)
        begin
            s1_next.msgn[k]  = mom[k][W-1];
            s1_next.mag[k]   = mom[k][W-1] ? (W'(0) - mom[k]) : mom[k];
            s1_next.mzero[k] = (mom[k] == '0);
            s1_next.fmag[k]  = fld[k][W-1] ? (W'(0) - fld[k]) : fld[k];
        end
    end

    // Track negative density over a run; clear after the last zone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (acc)
        begin
            seen_reg <= zone.last_zone ? 1'b0 : (seen_reg || zone.density_in[W-1]);
        end
    end

    // Front valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stages 1-4: partial products, squares, sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            for (int i = 0; i < 6; i++)
            begin
                logic [W-1:0] v;
                v = (i < 3) ? s1_reg.mag[i % 3] : s1_reg.fmag[i % 3];
                p00_reg[i] <= v[31:0] * v[31:0];
                p01_reg[i] <= v[31:0] * v[63:32];
                p11_reg[i] <= v[63:32] * v[63:32];
                sq_reg[i]  <= {p11_reg[i], 64'b0} + {31'b0, p01_reg[i], 33'b0}
                              + {64'b0, p00_reg[i]};
            end
            m2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            b2_reg <= sq_reg[3] + sq_reg[4] + sq_reg[5];
        end
    end

    // Dividers: three velocities and the kinetic term
    for (genvar k = 0; k < 3; k++)
    begin : g_vdiv
        mhdc_div_pipe u_vdiv (
            .clk (clk),
            .en  (en),
            .num ({32'b0, s4_reg.mag[k], 32'b0}),
            .den (s4_reg.rho),
            .quo (vq[k])
        );
    end

    mhdc_div_pipe u_kdiv (
        .clk (clk),
        .en  (en),
        .num (m2_reg),
        .den (s4_reg.rho),
        .quo (kq)
    );

    // Side data alongside the dividers
    always_comb
    begin
        dl_in.rho        = s4_reg.rho;
        dl_in.msgn       = s4_reg.msgn;
        dl_in.mzero      = s4_reg.mzero;
        dl_in.field      = s4_reg.field;
        dl_in.energy     = s4_reg.energy;
        dl_in.b2s        = b2_reg[NW-1:32];
        dl_in.m2nz       = (m2_reg != '0);
        dl_in.neg        = s4_reg.neg;
        dl_in.run_failed = s4_reg.run_failed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dlv_reg <= '0;
        end
        else if (en)
        begin
            dlv_reg <= {dlv_reg[NS-2:0], s4_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_reg[0] <= dl_in;
            for (int i = 1; i < NS; i++)
            begin
                dl_reg[i] <= dl_reg[i-1];
            end
        end
    end

    // Post stage 1: saturate velocities, form kinb2
    always_comb
    begin
        dt = dl_reg[NS-1];
        p1_next = '0;
        p1_next.rho        = dt.rho;
        p1_next.field      = dt.field;
        p1_next.eng        = dt.energy;
        p1_next.neg        = dt.neg;
        p1_next.failed     = dt.neg;
        p1_next.run_failed = dt.run_failed;
        for (int k = 0; k < 3; k++)
        begin
            if (dt.mzero[k])
            begin
                p1_next.vel[k] = '0;
            end
            else if (dt.rho == '0)
            begin
                p1_next.vel[k] = dt.msgn[k] ? mhdc_pkg::SMIN_MAG : mhdc_pkg::SMAX;
            end
            else if (dt.msgn[k])
            begin
                p1_next.vel[k] = W'(0) - ((vq[k][NW-1:W] != '0 || vq[k][W-1:0] > mhdc_pkg::SMIN_MAG)
                                          ? mhdc_pkg::SMIN_MAG : vq[k][W-1:0]);
            end
            else
            begin
                p1_next.vel[k] = (vq[k][NW-1:W] != '0 || vq[k][W-1:0] > mhdc_pkg::SMAX)
                                 ? mhdc_pkg::SMAX : vq[k][W-1:0];
            end
        end
        kin  = (dt.rho == '0) ? {63'b0, dt.m2nz, 64'b0} : kq;
        ksum = kin + {32'b0, dt.b2s};
        p1_next.kinb2 = (ksum[NW-1:W] != '0) ? mhdc_pkg::SMAX : ksum[W:1];
    end

    // Post stage 2: floored energy, replace negative energy
    always_comb
    begin
        p2_next = p1_reg;
        fsum = {1'b0, fd_reg.nq[W-1:0]} + {1'b0, p1_reg.kinb2};
        if (gmo_reg == '0 || fq_big || fsum > {1'b0, mhdc_pkg::SMAX})
        begin
            p2_next.flr = mhdc_pkg::SMAX;
        end
        else
        begin
            p2_next.flr = fsum[W-1:0];
        end
        if (p1_reg.eng[W-1])
        begin
            p2_next.eng    = p2_next.flr;
            p2_next.failed = 1'b1;
        end
    end

    // Post stage 5: pressure, final floor
    always_comb
    begin
        p5_next = p4_reg;
        psum = {35'b0, p4_pa_reg[W-1:32]} + {3'b0, p4_pb_reg} + {1'b0, p4_pc_reg};
        if (p4_ok_reg)
        begin
            p5_pres_next = (psum[W+2:W-1] != '0) ? mhdc_pkg::SMAX : psum[W-1:0];
        end
        else if (gmo_reg != '0)
        begin
            p5_pres_next   = {1'b0, pfl_reg};
            p5_next.eng    = p4_reg.flr;
            p5_next.failed = 1'b1;
        end
        else
        begin
            p5_pres_next = '0;
        end
    end

    assign eng1 = p2_reg.eng;

    // Back valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= dlv_reg[NS-1];
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    // Post stages: compare, multiply in parts, sum and saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            p3_reg      <= p2_reg;
            p3_ok_reg   <= !eng1[W-1] && (eng1 >= p2_reg.kinb2);
            p3_diff_reg <= eng1 - p2_reg.kinb2;
            p4_reg      <= p3_reg;
            p4_ok_reg   <= p3_ok_reg;
            p4_pa_reg   <= p3_diff_reg[31:0] * gmo_reg[31:0];
            p4_pb_reg   <= p3_diff_reg[63:32] * gmo_reg[31:0];
            p4_pc_reg   <= (gmo_reg[32] ? {2'b0, p3_diff_reg} : (W+2)'(0))
                         + (gmo_reg[33] ? {1'b0, p3_diff_reg, 1'b0} : (W+2)'(0));
            p5_reg      <= p5_next;
            p5_pres_reg <= p5_pres_next;
        end
    end

    // Drive the result word
    assign prim.valid            = p5_valid_reg;
    assign prim.density_out      = p5_reg.rho;
    assign prim.velocity_x       = p5_reg.vel[0];
    assign prim.velocity_y       = p5_reg.vel[1];
    assign prim.velocity_z       = p5_reg.vel[2];
    assign prim.field_x_out      = p5_reg.field[0];
    assign prim.field_y_out      = p5_reg.field[1];
    assign prim.field_z_out      = p5_reg.field[2];
    assign prim.pressure_out     = p5_pres_reg;
    assign prim.energy_out       = p5_reg.eng;
    assign prim.zone_failed      = p5_reg.failed;
    assign prim.negative_density = p5_reg.neg;
    assign prim.run_failed       = p5_reg.run_failed;

endmodule

`default_nettype wire

// ===== rtl/core/mhdc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhdc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           cfg_we,
    input wire logic [mhdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [63:0]                    density_out,
    input wire logic [63:0]                    pressure_out,
    input wire logic                           zone_failed,
    input wire logic                           negative_density
);

    // A floor-quotient restart blocks new zones
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == mhdc_pkg::CFG_GAMMA_MINUS_ONE ||
                   cfg_index == mhdc_pkg::CFG_PRESSURE_FLOOR) |=> !in_ready)
        else $error("zone accepted during floor division restart");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(density_out)
                                    && $stable(pressure_out))
        else $error("stalled result word changed");

    // Density and pressure never come out negative
    a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !density_out[63] && !pressure_out[63])
        else $error("negative density or pressure");

    // A density floor counts as a zone failure
    a_neg_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && negative_density |-> zone_failed)
        else $error("negative density without zone failure");

endmodule

bind mhd_conservative_to_primitive mhdc_checker u_mhdc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .in_ready         (zone.ready),
    .out_valid        (prim.valid),
    .out_ready        (prim.ready),
    .density_out      (prim.density_out),
    .pressure_out     (prim.pressure_out),
    .zone_failed      (prim.zone_failed),
    .negative_density (prim.negative_density)
);

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [63:0] rho;
        logic [63:0] mom [3];
        logic [63:0] fld [3];
        logic [63:0] eng;
        logic        last;
    } zone_t;

    typedef struct {
        logic [63:0] rho;
        logic [63:0] vel [3];
        logic [63:0] fld [3];
        logic [63:0] pres;
        logic [63:0] eng;
        logic        failed;
        logic        neg_rho;
        logic        run_failed;
    } prim_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int LONG_HOLD      = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [mhdc_pkg::CFG_IDX_W-1:0] cfg_index = mhdc_pkg::CFG_GAMMA_MINUS_ONE;
    logic [mhdc_pkg::FLOOR_W-1:0]   cfg_data = '0;

    mhdc_zone_if zone ();
    mhdc_prim_if prim ();

    mhd_conservative_to_primitive u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .zone      (zone.sink),
        .prim      (prim.source)
    );

    always #4 clk = ~clk;

    // Mirror of the block's registers and run state
    logic [mhdc_pkg::GAMMA_W-1:0] gamma_m1 = mhdc_pkg::GAMMA_RESET;
    logic [mhdc_pkg::FLOOR_W-1:0] rho_floor = mhdc_pkg::DFLOOR_RESET;
    logic [mhdc_pkg::FLOOR_W-1:0] pres_floor = mhdc_pkg::PFLOOR_RESET;
    logic                         run_rho_fail = 1'b0;

    zone_t zone_backlog [$];
    prim_t prim_expected [$];
    zone_t zone_cur;

    int src_idle = 0;
    int sink_idle = 0;
    int hold_req = 0;
    int hold_done = 0;
    int hold_cnt = 0;
    int errors = 0;
    int zones_done = 0;
    int zones_failed = 0;
    int runs_flagged = 0;
    int quiet = 0;

    function automatic logic [63:0] clamp(input logic [127:0] a);
        return (a[127:64] != 0 || a[63]) ? mhdc_pkg::SMAX : a[63:0];
    endfunction

    function automatic logic [63:0] floor_energy(input logic [63:0] kinb2);
        logic [127:0] q;
        if (gamma_m1 == 0)
            return mhdc_pkg::SMAX;
        q = ({65'd0, pres_floor} << 32) / {94'd0, gamma_m1};
        return clamp(q + {64'd0, kinb2});
    endfunction

    // Work out the primitive word for one conserved zone; advances run state
    function automatic prim_t convert_zone(input zone_t z);
        prim_t        p;
        logic [63:0]  rho, mag, fmag, kinb2, eng, m2mag;
        logic [127:0] msq, bsq, q, kin;
        logic         neg;
        msq = '0;
        bsq = '0;
        neg = z.rho[63];
        rho = neg ? {1'b0, rho_floor} : z.rho;
        p.failed = neg;
        for (int k = 0; k < 3; k++) begin
            mag  = z.mom[k][63] ? -z.mom[k] : z.mom[k];
            fmag = z.fld[k][63] ? -z.fld[k] : z.fld[k];
            msq  = msq + {64'd0, mag} * {64'd0, mag};
            bsq  = bsq + {64'd0, fmag} * {64'd0, fmag};
            if (mag == 0) begin
                p.vel[k] = '0;
            end else if (rho == 0) begin
                p.vel[k] = z.mom[k][63] ? mhdc_pkg::SMIN_MAG : mhdc_pkg::SMAX;
            end else begin
                q = ({64'd0, mag} << 32) / {64'd0, rho};
                if (z.mom[k][63]) begin
                    m2mag = (q[127:64] != 0 || q[63:0] > mhdc_pkg::SMIN_MAG)
                            ? mhdc_pkg::SMIN_MAG : q[63:0];
                    p.vel[k] = -m2mag;
                end else begin
                    p.vel[k] = clamp(q);
                end
            end
            p.fld[k] = z.fld[k];
        end
        if (rho == 0)
            kin = (msq != 0) ? (128'd1 << 64) : '0;
        else
            kin = msq / {64'd0, rho};
        kinb2 = clamp((kin + (bsq >> 32)) >> 1);
        eng = z.eng;
        if (eng[63]) begin
            eng = floor_energy(kinb2);
            p.failed = 1'b1;
        end
        if (!eng[63] && eng >= kinb2) begin
            p.pres = clamp(({64'd0, eng - kinb2} * {94'd0, gamma_m1}) >> 32);
        end else if (gamma_m1 != 0) begin
            p.pres = {1'b0, pres_floor};
            eng = floor_energy(kinb2);
            p.failed = 1'b1;
        end else begin
            p.pres = '0;
        end
        if (neg)
            run_rho_fail = 1'b1;
        p.run_failed = z.last && run_rho_fail;
        if (z.last)
            run_rho_fail = 1'b0;
        p.rho = rho;
        p.eng = eng;
        p.neg_rho = neg;
        return p;
    endfunction

    function automatic zone_t make_zone(input logic [63:0] rho, mx, my, mz,
                                        bx, by, bz, e, input logic last);
        zone_t z;
        z.rho = rho;
        z.mom[0] = mx; z.mom[1] = my; z.mom[2] = mz;
        z.fld[0] = bx; z.fld[1] = by; z.fld[2] = bz;
        z.eng = e;
        z.last = last;
        return z;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Moderate signed value: sign-extended 32-bit word shifted up
    function automatic logic [63:0] rand_mod();
        logic [31:0] r;
        r = $urandom;
        return {{32{r[31]}}, r} <<< $urandom_range(0, 24);
    endfunction

    function automatic zone_t rand_zone();
        zone_t z;
        int    kind;
        kind = $urandom_range(0, 99);
        z = make_zone({24'd0, 8'($urandom_range(1, 255)), 32'($urandom)},
                      rand_mod(), rand_mod(), rand_mod(),
                      rand_mod(), rand_mod(), rand_mod(),
                      {1'b0, 63'(rand_word())} >> $urandom_range(0, 40),
                      $urandom_range(0, 7) == 0);
        if (kind < 10) begin
            z.rho = rand_word();
            for (int k = 0; k < 3; k++) begin
                z.mom[k] = rand_word();
                z.fld[k] = rand_word();
            end
            z.eng = rand_word();
        end else if (kind < 20) begin
            z.rho[63] = 1'b1;
        end else if (kind < 24) begin
            z.rho = '0;
        end else if (kind < 32) begin
            z.eng[63] = 1'b1;
        end else if (kind < 42) begin
            z.eng = 64'($urandom);
        end
        return z;
    endfunction

    // Drive zones from the backlog
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            zone.valid <= 1'b0;
        end else begin
            if (zone.valid && zone.ready)
                prim_expected.push_back(convert_zone(zone_cur));
            if (!zone.valid || zone.ready) begin
                if (zone_backlog.size() > 0 && $urandom_range(0, 99) >= src_idle) begin
                    zone_cur = zone_backlog.pop_front();
                    zone.valid      <= 1'b1;
                    zone.density_in <= zone_cur.rho;
                    zone.momentum_x <= zone_cur.mom[0];
                    zone.momentum_y <= zone_cur.mom[1];
                    zone.momentum_z <= zone_cur.mom[2];
                    zone.field_x_in <= zone_cur.fld[0];
                    zone.field_y_in <= zone_cur.fld[1];
                    zone.field_z_in <= zone_cur.fld[2];
                    zone.energy_in  <= zone_cur.eng;
                    zone.last_zone  <= zone_cur.last;
                end else begin
                    zone.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        zone.density_in = '0; zone.momentum_x = '0; zone.momentum_y = '0;
        zone.momentum_z = '0; zone.field_x_in = '0; zone.field_y_in = '0;
        zone.field_z_in = '0; zone.energy_in = '0; zone.last_zone = 1'b0;
    end

    // Drive prim.ready: random stalls, or a long hold when requested
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prim.ready <= 1'b0;
        end else if (hold_req != hold_done) begin
            hold_done <= hold_req;
            hold_cnt <= LONG_HOLD;
            prim.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            prim.ready <= 1'b0;
        end else begin
            prim.ready <= $urandom_range(0, 99) >= sink_idle;
        end
    end

    task automatic report_mismatch(input string name, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on zone %0d: %s got %h expected %h", zones_done, name, got, want);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    // Check each primitive word against the oldest expectation
    always @(posedge clk) begin
        prim_t w;
        if (rst_n && prim.valid && prim.ready) begin
            if (prim_expected.size() == 0) begin
                report_mismatch("unexpected word", 64'(prim.density_out), 64'd0);
            end else begin
                w = prim_expected.pop_front();
                check_field("density_out", prim.density_out, w.rho);
                check_field("velocity_x", prim.velocity_x, w.vel[0]);
                check_field("velocity_y", prim.velocity_y, w.vel[1]);
                check_field("velocity_z", prim.velocity_z, w.vel[2]);
                check_field("field_x_out", prim.field_x_out, w.fld[0]);
                check_field("field_y_out", prim.field_y_out, w.fld[1]);
                check_field("field_z_out", prim.field_z_out, w.fld[2]);
                check_field("pressure_out", prim.pressure_out, w.pres);
                check_field("energy_out", prim.energy_out, w.eng);
                check_field("zone_failed", 64'(prim.zone_failed), 64'(w.failed));
                check_field("negative_density", 64'(prim.negative_density), 64'(w.neg_rho));
                check_field("run_failed", 64'(prim.run_failed), 64'(w.run_failed));
                zones_failed += w.failed;
                runs_flagged += w.run_failed;
            end
            zones_done++;
        end
    end

    // Watchdog: count cycles with work outstanding but no word moving
    always @(posedge clk) begin
        if ((zone.valid && zone.ready) || (prim.valid && prim.ready))
            quiet <= 0;
        else if (zone_backlog.size() > 0 || prim_expected.size() > 0)
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d words outstanding", prim_expected.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input mhdc_pkg::cfg_index_t idx,
                             input logic [mhdc_pkg::FLOOR_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            mhdc_pkg::CFG_GAMMA_MINUS_ONE: gamma_m1 = value[mhdc_pkg::GAMMA_W-1:0];
            mhdc_pkg::CFG_DENSITY_FLOOR:   rho_floor = value;
            mhdc_pkg::CFG_PRESSURE_FLOOR:  pres_floor = value;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [mhdc_pkg::GAMMA_W-1:0] g,
                            input logic [mhdc_pkg::FLOOR_W-1:0] df,
                            input logic [mhdc_pkg::FLOOR_W-1:0] pf);
        write_reg(mhdc_pkg::CFG_GAMMA_MINUS_ONE, mhdc_pkg::FLOOR_W'(g));
        write_reg(mhdc_pkg::CFG_DENSITY_FLOOR, df);
        write_reg(mhdc_pkg::CFG_PRESSURE_FLOOR, pf);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        @(posedge clk);
        while (zone_backlog.size() > 0 || zone.valid || prim_expected.size() > 0)
            @(posedge clk);
    endtask

    task automatic queue_random(input int n);
        repeat (n) zone_backlog.push_back(rand_zone());
    endtask

    localparam logic [63:0] ONE = 64'h1_0000_0000;
    localparam logic [63:0] MAXW = mhdc_pkg::SMAX;
    localparam logic [63:0] MINW = mhdc_pkg::SMIN_MAG;

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed zones under reset registers
        src_idle = 17;
        sink_idle = 56;
        zone_backlog.push_back(make_zone(ONE, 0, 0, 0, 0, 0, 0, ONE, 1'b0));
        zone_backlog.push_back(make_zone('0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        zone_backlog.push_back(make_zone(MAXW, MAXW, MINW, 0, MAXW, MINW, 0, MAXW, 1'b0));
        zone_backlog.push_back(make_zone(ONE, MAXW, MINW, MINW, MAXW, MAXW, MINW, MAXW, 1'b0));
        zone_backlog.push_back(make_zone(1, MINW, MAXW, 1, 0, 0, 0, ONE, 1'b0));
        zone_backlog.push_back(make_zone(MINW, ONE, -ONE, 0, ONE, 0, 0, 10 * ONE, 1'b0));
        zone_backlog.push_back(make_zone(ONE, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        zone_backlog.push_back(make_zone('0, ONE, -ONE, 0, 0, 0, 0, ONE, 1'b0));
        zone_backlog.push_back(make_zone('0, 0, 0, 0, ONE, ONE, ONE, ONE, 1'b1));
        zone_backlog.push_back(make_zone(ONE, ONE, 0, 0, 0, 0, 0, MINW, 1'b0));
        zone_backlog.push_back(make_zone(ONE, -64'sd1, 0, 0, 0, 0, 0, -ONE, 1'b0));
        zone_backlog.push_back(make_zone(ONE, 10 * ONE, 0, 0, 0, 0, 0, ONE, 1'b0));
        zone_backlog.push_back(make_zone(-64'sd1, 10 * ONE, 0, 0, 0, 0, 0, ONE, 1'b0));
        zone_backlog.push_back(make_zone(2 * ONE, 0, 0, 0, 0, 0, 0, ONE, 1'b1));
        zone_backlog.push_back(make_zone(2 * ONE, 0, 0, 0, 0, 0, 0, ONE, 1'b1));
        zone_backlog.push_back(make_zone(ONE, 0, 0, 0, 4 * ONE, 0, 0, 8 * ONE, 1'b1));
        zone_backlog.push_back(make_zone(1, ONE, ONE, ONE, 0, 0, 0, MAXW, 1'b0));
        zone_backlog.push_back(make_zone(MAXW, 1, -64'sd1, 0, -64'sd1, 1, 0, 1, 1'b1));
        queue_random(50);

        // Hold the sender until every expected word is back
        drain();
        queue_random(50);
        drain();

        // Gamma minus one of 2.0, zero density floor, largest pressure floor
        set_regs(34'h2_0000_0000, '0, {mhdc_pkg::FLOOR_W{1'b1}});
        src_idle = 56;
        sink_idle = 17;
        zone_backlog.push_back(make_zone(MINW, ONE, -ONE, 0, 0, 0, 0, ONE, 1'b1));
        zone_backlog.push_back(make_zone(-ONE, 0, 0, 0, ONE, 0, 0, MINW, 1'b0));
        queue_random(100);
        drain();

        // Smallest nonzero gamma minus one, largest density floor, zero pressure floor;
        // a long output hold lets the pipeline fill and back up
        set_regs(34'd1, {mhdc_pkg::FLOOR_W{1'b1}}, '0);
        src_idle = 0;
        sink_idle = 0;
        hold_req++;
        zone_backlog.push_back(make_zone(MINW, MAXW, MINW, 1, 0, 0, 0, MINW, 1'b1));
        queue_random(100);
        drain();

        // Gamma minus one of 0.4 with moderate floors, still with no idling
        set_regs(34'h0_6666_6666, 64'h0000_0000_8000_0000, 64'h0000_0000_0100_0000);
        queue_random(100);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("converted %0d zones over four register settings, %0d with floors applied",
                 zones_done, zones_failed);
        $display("%0d runs reported a negative density, %0d mismatches", runs_flagged, errors);
        if (errors == 0 && prim_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
